// ===== rtl/tl_pkg.sv =====
package tl_pkg;

	localparam logic [2:0] KIND_START = 3'd0;
	localparam logic [2:0] KIND_RMC   = 3'd1;
	localparam logic [2:0] KIND_PPS   = 3'd2;
	localparam logic [2:0] KIND_CHECK = 3'd3;
	localparam logic [2:0] KIND_SW    = 3'd4;
	localparam logic [2:0] KIND_MAG   = 3'd5;

	localparam logic [2:0] ST_SEARCH  = 3'd0;
	localparam logic [2:0] ST_SET     = 3'd1;
	localparam logic [2:0] ST_CAN_SW  = 3'd2;
	localparam logic [2:0] ST_CAN_MAG = 3'd3;
	localparam logic [2:0] ST_TIMEOUT = 3'd4;

	localparam logic [2:0] COUNT_MAX = 3'd7;
	localparam logic [2:0] MIN_VALID = 3'd4;
	localparam int         IN_W      = 184;
	localparam int         OUT_W     = 112;

	// a - b in milliseconds, both given as seconds plus ms
	function automatic logic signed [44:0] stamp_diff(input logic [31:0] a_s,
		input logic [9:0] a_ms, input logic [31:0] b_s, input logic [9:0] b_ms);
		logic signed [32:0] ds;
		logic signed [44:0] res;
		ds  = $signed({1'b0, a_s}) - $signed({1'b0, b_s});
		res = 45'(ds) * 45'sd1000 + 45'($signed({1'b0, a_ms}))
			- 45'($signed({1'b0, b_ms}));
		return res;
	endfunction

	function automatic logic [2:0] sat_inc(input logic [2:0] c);
		return (c < COUNT_MAX) ? 3'(c + 3'd1) : c;
	endfunction

endpackage

// ===== rtl/gps_pps_time_lock.sv =====
// GPS PPS time lock. Each input item is one event (start, RMC sentence, PPS
// pulse, clock check, switch cancel, magnetic cancel) and yields exactly one
// result item carrying the search status. Most events give their result in the
// cycle after acceptance. The PPS event that locks the time runs the expected
// timer value through a bit-serial modulo by the timer period, one bit per
// cycle; its result shows after the 32 modulo steps, a step that takes the
// remainder and a step that loads the output once it is free. No new item is
// taken meanwhile. A finished result sits in an output register, and the next
// item is taken while it waits if the sink takes it in that cycle. The user
// must write timeout_seconds via cfg_wen/cfg_wdata only while idle; unenforced.
module gps_pps_time_lock (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wen,
	input  logic [31:0]               cfg_wdata,
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	// kind
	input  logic [2:0]                s_axis_tuser,
	// rmc_active, rmc_subsecond_ms, rmc_utc_seconds, local_seconds, local_ms,
	// timer_capture, timer_period, timer_nominal_hz, zero pad
	input  logic [tl_pkg::IN_W-1:0]   s_axis_tdata,
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	// status
	output logic [2:0]                m_axis_tuser,
	// time_to_set, offset_ms, measured_hz
	output logic [tl_pkg::OUT_W-1:0]  m_axis_tdata
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_MOD  = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;

	// input fields
	logic        in_active;
	logic [9:0]  in_sub_ms;
	logic [31:0] in_utc, in_lsec, in_cap, in_per, in_nom;
	logic [9:0]  in_lms;
	logic [2:0]  kind;

	assign kind      = s_axis_tuser;
	assign in_active = s_axis_tdata[0];
	assign in_sub_ms = s_axis_tdata[10:1];
	assign in_utc    = s_axis_tdata[42:11];
	assign in_lsec   = s_axis_tdata[74:43];
	assign in_lms    = s_axis_tdata[84:75];
	assign in_cap    = s_axis_tdata[116:85];
	assign in_per    = s_axis_tdata[148:117];
	assign in_nom    = s_axis_tdata[180:149];

	// search state
	logic [1:0]  state_q;
	logic [31:0] timeout_q;
	logic [2:0]  rc_q, pc_q, fs_q;
	logic [31:0] pend_q;
	logic [31:0] rmc_s_q, pps_s_q, prev_cap_q;
	logic [9:0]  rmc_ms_q, pps_ms_q;

	// held for the lock item
	logic [31:0] tset_q, cap_q, per_q, nom_q, exp_q;
	logic [47:0] off_q;

	// output register
	logic                     m_valid_q;
	logic [2:0]               m_user_q;
	logic [tl_pkg::OUT_W-1:0] m_data_q;

	logic out_free, acc;
	assign out_free      = !m_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE) && out_free;
	assign acc           = s_axis_tvalid && s_axis_tready;

	// since-last: RMC measures from last PPS, PPS from last RMC
	logic [31:0]        ref_s;
	logic [9:0]         ref_ms;
	logic signed [44:0] since, off_full;
	logic               since_ok;

	assign ref_s    = (kind == tl_pkg::KIND_RMC) ? pps_s_q : rmc_s_q;
	assign ref_ms   = (kind == tl_pkg::KIND_RMC) ? pps_ms_q : rmc_ms_q;
	assign since    = tl_pkg::stamp_diff(in_lsec, in_lms, ref_s, ref_ms);
	assign since_ok = since < 45'sd1000;
	assign off_full = tl_pkg::stamp_diff(in_lsec, in_lms, pend_q, 10'd0);

	// next search state for an accepted item
	logic [2:0]  n_rc, n_pc, n_fs;
	logic [31:0] n_pend;
	logic        lock;

	always_comb begin
		n_rc   = rc_q;
		n_pc   = pc_q;
		n_fs   = fs_q;
		n_pend = pend_q;
		lock   = 1'b0;
		if (kind == tl_pkg::KIND_START) begin
			n_rc   = '0;
			n_pc   = '0;
			n_pend = '0;
			n_fs   = (timeout_q == 32'd0) ? tl_pkg::ST_TIMEOUT : tl_pkg::ST_SEARCH;
		end else if (fs_q == tl_pkg::ST_SEARCH) begin
			case (kind)
				tl_pkg::KIND_RMC: begin
					if (in_active) begin
						if (in_sub_ms == 10'd0 && since_ok) begin
							n_rc = tl_pkg::sat_inc(rc_q);
							if (n_rc > tl_pkg::MIN_VALID)
								n_pend = 32'(in_utc + 32'd1);
						end else begin
							n_rc   = '0;
							n_pc   = '0;
							n_pend = '0;
						end
					end
				end
				tl_pkg::KIND_PPS: begin
					if (since_ok) begin
						n_pc = tl_pkg::sat_inc(pc_q);
						if (n_pc > tl_pkg::MIN_VALID && pend_q != 32'd0) begin
							lock = 1'b1;
							n_fs = tl_pkg::ST_SET;
						end
					end else begin
						n_rc   = '0;
						n_pc   = '0;
						n_pend = '0;
					end
				end
				tl_pkg::KIND_CHECK: begin
					if (in_lsec >= timeout_q) n_fs = tl_pkg::ST_TIMEOUT;
				end
				tl_pkg::KIND_SW:  n_fs = tl_pkg::ST_CAN_SW;
				tl_pkg::KIND_MAG: n_fs = tl_pkg::ST_CAN_MAG;
				default: ;
			endcase
		end
	end

	// record arrival times only while searching
	logic rec_rmc, rec_pps;
	assign rec_rmc = acc && fs_q == tl_pkg::ST_SEARCH && kind == tl_pkg::KIND_RMC;
	assign rec_pps = acc && fs_q == tl_pkg::ST_SEARCH && kind == tl_pkg::KIND_PPS;

	// output register gets a new item
	logic m_set;
	assign m_set = (state_q == S_IDLE && acc && !lock) || (state_q == S_FIN && out_free);

	// serial modulo: expected = (prev + nominal) mod period
	logic        mod_done;
	logic [31:0] mod_rem;

	tl_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (acc && lock),
		.dividend (32'(prev_cap_q + in_nom)),
		.modulus  (in_per),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	// frequency from expected vs captured timer value
	logic [31:0] half, dd, hz;
	always_comb begin
		half = (per_q == 32'd0) ? 32'h8000_0000 : {1'b0, per_q[31:1]};
		if (exp_q > cap_q) begin
			dd = 32'(exp_q - cap_q);
			hz = (dd < half) ? 32'(nom_q - dd) : 32'(nom_q + cap_q - exp_q + per_q);
		end else begin
			dd = 32'(cap_q - exp_q);
			hz = (dd < half) ? 32'(nom_q + dd) : 32'(nom_q - (exp_q - cap_q + per_q));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			timeout_q  <= '0;
			rc_q       <= '0;
			pc_q       <= '0;
			fs_q       <= tl_pkg::ST_SEARCH;
			pend_q     <= '0;
			rmc_s_q    <= '0;
			rmc_ms_q   <= '0;
			pps_s_q    <= '0;
			pps_ms_q   <= '0;
			prev_cap_q <= '0;
			m_valid_q  <= 1'b0;
		end else begin
			if (cfg_wen) timeout_q <= cfg_wdata;
			if (m_set) m_valid_q <= 1'b1;
			else if (m_axis_tready) m_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						rc_q   <= n_rc;
						pc_q   <= n_pc;
						fs_q   <= n_fs;
						pend_q <= n_pend;
						if (rec_rmc) begin
							rmc_s_q  <= in_lsec;
							rmc_ms_q <= in_lms;
						end
						if (rec_pps) begin
							pps_s_q    <= in_lsec;
							pps_ms_q   <= in_lms;
							prev_cap_q <= in_cap;
						end
						if (lock) state_q <= S_MOD;
					end
				end
				S_MOD: begin
					if (mod_done) state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc && lock) begin
			tset_q <= pend_q;
			off_q  <= {{3{off_full[44]}}, off_full};
			cap_q  <= in_cap;
			per_q  <= in_per;
			nom_q  <= in_nom;
		end
		if (state_q == S_MOD && mod_done) exp_q <= mod_rem;
		if (state_q == S_IDLE && acc && !lock) begin
			m_user_q <= n_fs;
			m_data_q <= '0;
		end else if (state_q == S_FIN && out_free) begin
			m_user_q <= tl_pkg::ST_SET;
			m_data_q <= {hz, off_q, tset_q};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = m_user_q;
	assign m_axis_tdata  = m_data_q;

endmodule

// ===== rtl/tl_mod.sv =====
// Bit-serial restoring modulo, one dividend bit per cycle.
// modulus zero stands for 2^32.
module tl_mod (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] modulus,
	output logic        done,
	output logic [31:0] rem
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [31:0] x_q;
	logic [31:0] rem_q;
	logic [32:0] m_q;
	logic [32:0] trial;

	assign trial = {rem_q, x_q[31]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= 5'(cnt_q + 5'd1);
			if (cnt_q == 5'd31) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= dividend;
			rem_q <= '0;
			m_q   <= {(modulus == 32'd0), modulus};
		end else if (busy_q) begin
			x_q   <= {x_q[30:0], 1'b0};
			rem_q <= (trial >= m_q) ? 32'(trial - m_q) : trial[31:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule
